// ----- design/pmu_pkg.sv -----
// ----------------------------------------------------------------------------
// pmu_pkg
// Shared types, widths and helpers for the particle motion update pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pmu_pkg;

  localparam int DataW  = 32;
  localparam int DtBits = 16;
  localparam int DragW  = 24;
  localparam int DampW  = DtBits + 1;
  localparam int DenW   = DataW + 1;
  localparam int AddrW  = 4;
  localparam int OneDt  = 1 << DtBits;

  typedef logic signed [DataW-1:0] fx_t;

  typedef enum logic [1:0] {
    CfgAttractX,
    CfgAttractY,
    CfgStrength,
    CfgSwirl
  } cfg_idx_e;

  typedef struct packed {
    fx_t attract_x;
    fx_t attract_y;
    fx_t attract_strength;
    fx_t attract_swirl;
  } cfg_t;

  // particle state carried down the pipe
  typedef struct packed {
    logic              alive;
    fx_t               pos_x;
    fx_t               pos_y;
    fx_t               vel_x;
    fx_t               vel_y;
    fx_t               life;
    logic [DtBits-1:0] dt;
    logic [DampW-1:0]  damp;
  } part_t;

  // attractor offset as sign and magnitude
  typedef struct packed {
    logic             sx;
    logic             sy;
    logic [DataW-1:0] adx;
    logic [DataW-1:0] ady;
  } ofs_t;

  function automatic fx_t sat32(input logic signed [63:0] v);
    fx_t r;
    if (v[63:DataW-1] == '0 || v[63:DataW-1] == '1) begin
      r = v[DataW-1:0];
    end else if (v[63]) begin
      r = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      r = {1'b0, {(DataW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ----- design/pmu_if.sv -----
// ----------------------------------------------------------------------------
// pmu_if
// Valid/ready channels for particle slots in and updated particles out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pmu_in_if;
  import pmu_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    alive_in;
  fx_t                     pos_x;
  fx_t                     pos_y;
  fx_t                     vel_x;
  fx_t                     vel_y;
  fx_t                     life_left;
  fx_t                     grav_accel;
  logic [DragW-1:0]        drag_coef;
  logic [DtBits-1:0]       time_step;

  modport source (
    output valid, alive_in, pos_x, pos_y, vel_x, vel_y, life_left, grav_accel,
           drag_coef, time_step,
    input  ready
  );
  modport sink (
    input  valid, alive_in, pos_x, pos_y, vel_x, vel_y, life_left, grav_accel,
           drag_coef, time_step,
    output ready
  );
endinterface

interface pmu_out_if;
  import pmu_pkg::*;

  logic valid;
  logic ready;
  logic alive_out;
  fx_t  new_pos_x;
  fx_t  new_pos_y;
  fx_t  new_vel_x;
  fx_t  new_vel_y;
  fx_t  new_life;

  modport source (
    output valid, alive_out, new_pos_x, new_pos_y, new_vel_x, new_vel_y, new_life,
    input  ready
  );
  modport sink (
    input  valid, alive_out, new_pos_x, new_pos_y, new_vel_x, new_vel_y, new_life,
    output ready
  );
endinterface

// ----- design/pmu_cfg.sv -----
// ----------------------------------------------------------------------------
// pmu_cfg
// APB register file for the attractor position, pull and swirl strengths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pmu_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pmu_pkg::AddrW-1:0]  paddr,
  input  logic [pmu_pkg::DataW-1:0]  pwdata,
  output logic [pmu_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output pmu_pkg::cfg_t              cfg_o
);
  import pmu_pkg::*;

  cfg_t     cfg_q;
  cfg_idx_e idx;
  logic     wr;

  assign idx = cfg_idx_e'(paddr[AddrW-1:2]);
  assign wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr) begin
      unique case (idx)
        CfgAttractX: cfg_q.attract_x        <= fx_t'(pwdata);
        CfgAttractY: cfg_q.attract_y        <= fx_t'(pwdata);
        CfgStrength: cfg_q.attract_strength <= fx_t'(pwdata);
        CfgSwirl:    cfg_q.attract_swirl    <= fx_t'(pwdata);
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      CfgAttractX: prdata = cfg_q.attract_x;
      CfgAttractY: prdata = cfg_q.attract_y;
      CfgStrength: prdata = cfg_q.attract_strength;
      CfgSwirl:    prdata = cfg_q.attract_swirl;
    endcase
  end

  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

endmodule

// ----- design/pmu_sqrt.sv -----
// ----------------------------------------------------------------------------
// pmu_sqrt
// Pipelined integer square root of a 64-bit radicand, one root bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pmu_sqrt #(
  parameter int SideW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [63:0]      rad_i,
  input  logic [SideW-1:0] side_i,
  output logic             vld_o,
  output logic [31:0]      root_o,
  output logic [SideW-1:0] side_o
);
  import pmu_pkg::*;

  localparam int Steps = 32;
  localparam int RemW  = 35;

  logic             vld_q  [Steps];
  logic [RemW-1:0]  rem_q  [Steps];
  logic [31:0]      root_q [Steps];
  logic [63:0]      rad_q  [Steps];
  logic [SideW-1:0] side_q [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_stage
    logic             vld_s;
    logic [RemW-1:0]  rem_s;
    logic [RemW-1:0]  rem_t;
    logic [RemW-1:0]  trial;
    logic [31:0]      root_s;
    logic [63:0]      rad_s;
    logic [SideW-1:0] side_s;

    if (k == 0) begin : g_first
      assign vld_s  = vld_i;
      assign rem_s  = '0;
      assign root_s = '0;
      assign rad_s  = rad_i;
      assign side_s = side_i;
    end else begin : g_next
      assign vld_s  = vld_q[k-1];
      assign rem_s  = rem_q[k-1];
      assign root_s = root_q[k-1];
      assign rad_s  = rad_q[k-1];
      assign side_s = side_q[k-1];
    end

    assign rem_t = {rem_s[RemW-3:0], rad_s[2*(Steps-1-k) +: 2]};
    assign trial = {1'b0, root_s, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= rad_s;
        side_q[k] <= side_s;
        if (rem_t >= trial) begin
          rem_q[k]  <= rem_t - trial;
          root_q[k] <= {root_s[30:0], 1'b1};
        end else begin
          rem_q[k]  <= rem_t;
          root_q[k] <= {root_s[30:0], 1'b0};
        end
      end
    end
  end

  assign vld_o  = vld_q[Steps-1];
  assign root_o = root_q[Steps-1];
  assign side_o = side_q[Steps-1];

endmodule

// ----- design/pmu_div.sv -----
// ----------------------------------------------------------------------------
// pmu_div
// Dual pipelined restoring divider, one quotient bit per stage; the dividends
// are below the shared divisor, so the quotients are pure fractions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pmu_div #(
  parameter int QuotW = 16,
  parameter int SideW = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      vld_i,
  input  logic [pmu_pkg::DataW-1:0] num_x_i,
  input  logic [pmu_pkg::DataW-1:0] num_y_i,
  input  logic [pmu_pkg::DenW-1:0]  den_i,
  input  logic [SideW-1:0]          side_i,
  output logic                      vld_o,
  output logic [QuotW-1:0]          quot_x_o,
  output logic [QuotW-1:0]          quot_y_o,
  output logic [SideW-1:0]          side_o
);
  import pmu_pkg::*;

  localparam int RemW = DenW + 1;

  logic             vld_q  [QuotW];
  logic [RemW-1:0]  rx_q   [QuotW];
  logic [RemW-1:0]  ry_q   [QuotW];
  logic [QuotW-1:0] qx_q   [QuotW];
  logic [QuotW-1:0] qy_q   [QuotW];
  logic [DenW-1:0]  den_q  [QuotW];
  logic [SideW-1:0] side_q [QuotW];

  for (genvar k = 0; k < QuotW; k++) begin : g_stage
    logic             vld_s;
    logic [RemW-1:0]  rx_s;
    logic [RemW-1:0]  ry_s;
    logic [QuotW-1:0] qx_s;
    logic [QuotW-1:0] qy_s;
    logic [DenW-1:0]  den_s;
    logic [SideW-1:0] side_s;
    logic [RemW-1:0]  tx;
    logic [RemW-1:0]  ty;
    logic [RemW-1:0]  dd;

    if (k == 0) begin : g_first
      assign vld_s  = vld_i;
      assign rx_s   = RemW'(num_x_i);
      assign ry_s   = RemW'(num_y_i);
      assign qx_s   = '0;
      assign qy_s   = '0;
      assign den_s  = den_i;
      assign side_s = side_i;
    end else begin : g_next
      assign vld_s  = vld_q[k-1];
      assign rx_s   = rx_q[k-1];
      assign ry_s   = ry_q[k-1];
      assign qx_s   = qx_q[k-1];
      assign qy_s   = qy_q[k-1];
      assign den_s  = den_q[k-1];
      assign side_s = side_q[k-1];
    end

    assign tx = {rx_s[RemW-2:0], 1'b0};
    assign ty = {ry_s[RemW-2:0], 1'b0};
    assign dd = {1'b0, den_s};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k]  <= den_s;
        side_q[k] <= side_s;
        if (tx >= dd) begin
          rx_q[k] <= tx - dd;
          qx_q[k] <= {qx_s[QuotW-2:0], 1'b1};
        end else begin
          rx_q[k] <= tx;
          qx_q[k] <= {qx_s[QuotW-2:0], 1'b0};
        end
        if (ty >= dd) begin
          ry_q[k] <= ty - dd;
          qy_q[k] <= {qy_s[QuotW-2:0], 1'b1};
        end else begin
          ry_q[k] <= ty;
          qy_q[k] <= {qy_s[QuotW-2:0], 1'b0};
        end
      end
    end
  end

  assign vld_o    = vld_q[QuotW-1];
  assign quot_x_o = qx_q[QuotW-1];
  assign quot_y_o = qy_q[QuotW-1];
  assign side_o   = side_q[QuotW-1];

endmodule

// ----- design/particle_motion_update.sv -----
// Throughput: one particle per cycle while out_o is not stalled; the 32-stage square root
// and the FRAC_BITS-stage divider are fully pipelined, the whole pipe advances as one.
// Reset: rst_ni clears all stage valids and the attractor registers to zero.
// ----------------------------------------------------------------------------
// particle_motion_update
// Euler step of one particle: life, gravity, attractor pull/swirl, drag, move.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module particle_motion_update #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  pmu_in_if.sink                     in_i,
  pmu_out_if.source                  out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pmu_pkg::AddrW-1:0]  paddr,
  input  logic [pmu_pkg::DataW-1:0]  pwdata,
  output logic [pmu_pkg::DataW-1:0]  prdata,
  output logic                       pready
);
  import pmu_pkg::*;

  localparam int NW      = FRAC_BITS + 1;
  localparam int PW      = NW + DataW;
  localparam int FxW     = DataW + 2;
  localparam int Eps0    = ((1 << FRAC_BITS) + 500) / 1000;
  localparam int Eps     = (Eps0 > 0) ? Eps0 : 1;
  localparam int SqSideW = $bits(part_t) + $bits(ofs_t);
  localparam int DvSideW = $bits(part_t) + 2;

  cfg_t cfg;
  logic en;
  logic attr_on;

  pmu_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign attr_on    = (cfg.attract_strength != '0) || (cfg.attract_swirl != '0);
  assign en         = ~out_o.valid | out_o.ready;
  assign in_i.ready = en;

  // stage 1: life, gravity and drag products, attractor offset
  logic [DtBits+FRAC_BITS-1:0] dt_wide;
  logic [FRAC_BITS-1:0]        dt_fx;
  fx_t                         life_dec;
  logic                        live_d;

  assign dt_wide  = {in_i.time_step, {FRAC_BITS{1'b0}}};
  assign dt_fx    = dt_wide[DtBits+FRAC_BITS-1:DtBits];
  assign life_dec = sat32(64'(in_i.life_left) - 64'({1'b0, dt_fx}));
  assign live_d   = in_i.alive_in & ~life_dec[DataW-1] & (life_dec != '0);

  logic                          s1_v_q;
  part_t                         s1_p_q;
  logic signed [DataW+DtBits:0]  s1_g_q;
  logic [DragW+DtBits-1:0]       s1_d_q;
  fx_t                           s1_dx_q;
  fx_t                           s1_dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_p_q.alive <= live_d;
      s1_p_q.pos_x <= in_i.pos_x;
      s1_p_q.pos_y <= in_i.pos_y;
      s1_p_q.vel_x <= in_i.vel_x;
      s1_p_q.vel_y <= in_i.vel_y;
      s1_p_q.life  <= in_i.alive_in ? life_dec : in_i.life_left;
      s1_p_q.dt    <= in_i.time_step;
      s1_p_q.damp  <= '0;
      s1_g_q       <= in_i.grav_accel * $signed({1'b0, in_i.time_step});
      s1_d_q       <= in_i.drag_coef * in_i.time_step;
      s1_dx_q      <= sat32(64'(cfg.attract_x) - 64'(in_i.pos_x));
      s1_dy_q      <= sat32(64'(cfg.attract_y) - 64'(in_i.pos_y));
    end
  end

  // stage 2: gravity add, damping factor, squares
  logic [DragW-1:0]  dsh;
  logic [DampW-1:0]  damp_d;

  assign dsh    = s1_d_q[DragW+DtBits-1:DtBits];
  assign damp_d = (dsh >= DragW'(OneDt)) ? '0 : DampW'(DragW'(OneDt) - dsh);

  logic              s2_v_q;
  part_t             s2_p_q;
  ofs_t              s2_o_q;
  logic signed [63:0] s2_sqx_q;
  logic signed [63:0] s2_sqy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_p_q      <= s1_p_q;
      s2_p_q.damp <= damp_d;
      if (s1_p_q.alive) begin
        s2_p_q.vel_y <= sat32(64'(s1_p_q.vel_y) + 64'(s1_g_q >>> DtBits));
      end
      s2_o_q.sx  <= s1_dx_q[DataW-1];
      s2_o_q.sy  <= s1_dy_q[DataW-1];
      s2_o_q.adx <= s1_dx_q[DataW-1] ? (~s1_dx_q + DataW'(1)) : s1_dx_q;
      s2_o_q.ady <= s1_dy_q[DataW-1] ? (~s1_dy_q + DataW'(1)) : s1_dy_q;
      s2_sqx_q   <= s1_dx_q * s1_dx_q;
      s2_sqy_q   <= s1_dy_q * s1_dy_q;
    end
  end

  // stage 3: squared distance
  logic        s3_v_q;
  part_t       s3_p_q;
  ofs_t        s3_o_q;
  logic [63:0] s3_rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_p_q   <= s2_p_q;
      s3_o_q   <= s2_o_q;
      s3_rad_q <= $unsigned(s2_sqx_q) + $unsigned(s2_sqy_q);
    end
  end

  // square root
  logic               sq_v;
  logic [31:0]        sq_root;
  logic [SqSideW-1:0] sq_side;
  part_t              sq_p;
  ofs_t               sq_o;

  pmu_sqrt #(
    .SideW (SqSideW)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s3_v_q),
    .rad_i  (s3_rad_q),
    .side_i ({s3_p_q, s3_o_q}),
    .vld_o  (sq_v),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  assign {sq_p, sq_o} = sq_side;

  // stage 4: distance plus epsilon
  logic             s4_v_q;
  part_t            s4_p_q;
  ofs_t             s4_o_q;
  logic [DenW-1:0]  s4_dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (en) begin
      s4_v_q <= sq_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_p_q    <= sq_p;
      s4_o_q    <= sq_o;
      s4_dist_q <= {1'b0, sq_root} + DenW'(Eps);
    end
  end

  // normalisation divide
  logic               dv_v;
  logic [FRAC_BITS-1:0] dv_qx;
  logic [FRAC_BITS-1:0] dv_qy;
  logic [DvSideW-1:0] dv_side;
  part_t              dv_p;
  logic               dv_sx;
  logic               dv_sy;

  pmu_div #(
    .QuotW (FRAC_BITS),
    .SideW (DvSideW)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (s4_v_q),
    .num_x_i  (s4_o_q.adx),
    .num_y_i  (s4_o_q.ady),
    .den_i    (s4_dist_q),
    .side_i   ({s4_p_q, s4_o_q.sx, s4_o_q.sy}),
    .vld_o    (dv_v),
    .quot_x_o (dv_qx),
    .quot_y_o (dv_qy),
    .side_o   (dv_side)
  );

  assign {dv_p, dv_sx, dv_sy} = dv_side;

  // stage 5: signed unit vector
  logic                 s5_v_q;
  part_t                s5_p_q;
  logic signed [NW-1:0] s5_nx_q;
  logic signed [NW-1:0] s5_ny_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
    end else if (en) begin
      s5_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_p_q  <= dv_p;
      s5_nx_q <= dv_sx ? -$signed({1'b0, dv_qx}) : $signed({1'b0, dv_qx});
      s5_ny_q <= dv_sy ? -$signed({1'b0, dv_qy}) : $signed({1'b0, dv_qy});
    end
  end

  // stage 6: pull and swirl products
  logic                 s6_v_q;
  part_t                s6_p_q;
  logic signed [PW-1:0] s6_pa_q;
  logic signed [PW-1:0] s6_pb_q;
  logic signed [PW-1:0] s6_pc_q;
  logic signed [PW-1:0] s6_pd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_v_q <= 1'b0;
    end else if (en) begin
      s6_v_q <= s5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_p_q  <= s5_p_q;
      s6_pa_q <= s5_nx_q * cfg.attract_strength;
      s6_pb_q <= s5_ny_q * cfg.attract_swirl;
      s6_pc_q <= s5_ny_q * cfg.attract_strength;
      s6_pd_q <= s5_nx_q * cfg.attract_swirl;
    end
  end

  // stage 7: force
  logic signed [PW:0]    sum_x;
  logic signed [PW:0]    sum_y;
  logic signed [PW:0]    shf_x;
  logic signed [PW:0]    shf_y;

  assign sum_x = (PW+1)'(s6_pa_q) - (PW+1)'(s6_pb_q);
  assign sum_y = (PW+1)'(s6_pc_q) + (PW+1)'(s6_pd_q);
  assign shf_x = sum_x >>> FRAC_BITS;
  assign shf_y = sum_y >>> FRAC_BITS;

  logic                  s7_v_q;
  part_t                 s7_p_q;
  logic signed [FxW-1:0] s7_fx_q;
  logic signed [FxW-1:0] s7_fy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_v_q <= 1'b0;
    end else if (en) begin
      s7_v_q <= s6_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_p_q  <= s6_p_q;
      s7_fx_q <= shf_x[FxW-1:0];
      s7_fy_q <= shf_y[FxW-1:0];
    end
  end

  // stage 8: force times dt
  logic                        s8_v_q;
  part_t                       s8_p_q;
  logic signed [FxW+DtBits:0]  s8_ax_q;
  logic signed [FxW+DtBits:0]  s8_ay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_v_q <= 1'b0;
    end else if (en) begin
      s8_v_q <= s7_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_p_q  <= s7_p_q;
      s8_ax_q <= s7_fx_q * $signed({1'b0, s7_p_q.dt});
      s8_ay_q <= s7_fy_q * $signed({1'b0, s7_p_q.dt});
    end
  end

  // stage 9: attractor velocity update
  logic  s9_v_q;
  part_t s9_p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s9_v_q <= 1'b0;
    end else if (en) begin
      s9_v_q <= s8_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s9_p_q <= s8_p_q;
      if (s8_p_q.alive && attr_on) begin
        s9_p_q.vel_x <= sat32(64'(s8_p_q.vel_x) + 64'(s8_ax_q >>> DtBits));
        s9_p_q.vel_y <= sat32(64'(s8_p_q.vel_y) + 64'(s8_ay_q >>> DtBits));
      end
    end
  end

  // stage 10: drag products
  logic                        s10_v_q;
  part_t                       s10_p_q;
  logic signed [DataW+DampW:0] s10_mx_q;
  logic signed [DataW+DampW:0] s10_my_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s10_v_q <= 1'b0;
    end else if (en) begin
      s10_v_q <= s9_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s10_p_q  <= s9_p_q;
      s10_mx_q <= s9_p_q.vel_x * $signed({1'b0, s9_p_q.damp});
      s10_my_q <= s9_p_q.vel_y * $signed({1'b0, s9_p_q.damp});
    end
  end

  // stage 11: damped velocity and displacement products
  logic signed [DataW+DampW:0] mx_sh;
  logic signed [DataW+DampW:0] my_sh;
  fx_t                         vdx;
  fx_t                         vdy;

  assign mx_sh = s10_mx_q >>> DtBits;
  assign my_sh = s10_my_q >>> DtBits;
  assign vdx   = mx_sh[DataW-1:0];
  assign vdy   = my_sh[DataW-1:0];

  logic                         s11_v_q;
  part_t                        s11_p_q;
  logic signed [DataW+DtBits:0] s11_px_q;
  logic signed [DataW+DtBits:0] s11_py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s11_v_q <= 1'b0;
    end else if (en) begin
      s11_v_q <= s10_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s11_p_q  <= s10_p_q;
      if (s10_p_q.alive) begin
        s11_p_q.vel_x <= vdx;
        s11_p_q.vel_y <= vdy;
      end
      s11_px_q <= vdx * $signed({1'b0, s10_p_q.dt});
      s11_py_q <= vdy * $signed({1'b0, s10_p_q.dt});
    end
  end

  // stage 12: position update, output register
  logic  s12_v_q;
  part_t s12_p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s12_v_q <= 1'b0;
    end else if (en) begin
      s12_v_q <= s11_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s12_p_q <= s11_p_q;
      if (s11_p_q.alive) begin
        s12_p_q.pos_x <= sat32(64'(s11_p_q.pos_x) + 64'(s11_px_q >>> DtBits));
        s12_p_q.pos_y <= sat32(64'(s11_p_q.pos_y) + 64'(s11_py_q >>> DtBits));
      end
    end
  end

  assign out_o.valid     = s12_v_q;
  assign out_o.alive_out = s12_p_q.alive;
  assign out_o.new_pos_x = s12_p_q.pos_x;
  assign out_o.new_pos_y = s12_p_q.pos_y;
  assign out_o.new_vel_x = s12_p_q.vel_x;
  assign out_o.new_vel_y = s12_p_q.vel_y;
  assign out_o.new_life  = s12_p_q.life;

`ifndef ASSERT_OFF
  // a live particle always leaves with positive life
  a_live_life: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.alive_out |-> !out_o.new_life[DataW-1] && out_o.new_life != '0)
    else $error("live particle with non-positive life");

  // divider input must be a proper fraction
  a_div_frac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_v_q |-> (s4_dist_q > {1'b0, s4_o_q.adx}) && (s4_dist_q > {1'b0, s4_o_q.ady}))
    else $error("distance not above offset magnitude");

  // the pipe only stalls with a result waiting at the output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid && !out_o.ready)
    else $error("pipeline stalled without a pending output");
`endif

endmodule
